@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL. They compile to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PWT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PWT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PWT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PWT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/pwt_pkg.sv @@
package pwt_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIX64   = 3'd1;
  localparam logic [2:0] KIND_FIX32   = 3'd2;
  localparam logic [2:0] KIND_LENHDR  = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_ZERO  = 3'd1;
  localparam logic [2:0] ERR_WIRE  = 3'd2;
  localparam logic [2:0] ERR_TRUNC = 3'd3;
  localparam logic [2:0] ERR_LONG  = 3'd4;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  localparam logic [3:0] VARINT_LAST = 4'd9;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [2:0]  error_code;
    logic        message_end;
  } tok_t;

  // Bit position of the seven-bit group held by varint byte n.
  function automatic logic [5:0] varint_shift(input logic [3:0] n);
    logic [5:0] s;
    unique case (n)
      4'd0:    s = 6'd0;
      4'd1:    s = 6'd7;
      4'd2:    s = 6'd14;
      4'd3:    s = 6'd21;
      4'd4:    s = 6'd28;
      4'd5:    s = 6'd35;
      4'd6:    s = 6'd42;
      4'd7:    s = 6'd49;
      4'd8:    s = 6'd56;
      4'd9:    s = 6'd63;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/pwt_in_stage.sv @@
module pwt_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pwt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  input  logic                            consume,
  output logic                            s_valid,
  output pwt_pkg::in_word_t               s_word
);
  import pwt_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     load;

  assign in_tready = !valid_r || consume;
  assign load      = in_tvalid && in_tready;
  assign valid_nxt = load || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r.data <= in_tdata;
      word_r.eom  <= in_tlast;
    end
  end

  assign s_valid = valid_r;
  assign s_word  = word_r;

endmodule

@@ rtl/core/pwt_core.sv @@
`include "assert_macros.svh"

module pwt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  input  pwt_pkg::in_word_t s_word,
  input  logic              out_free,
  output logic              consume,
  output logic              res_valid,
  output pwt_pkg::tok_t     res
);
  import pwt_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vcnt_r, vcnt_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] field_r, field_nxt;
  logic [2:0]  wire_r, wire_nxt;
  logic        err_lat_r, err_lat_nxt;

  logic        have;
  logic [2:0]  kind;
  logic [63:0] val;
  logic [2:0]  err;
  logic [31:0] efld;
  logic [2:0]  ewt;
  logic        restart;
  logic        emit;
  logic [63:0] vacc;
  logic [63:0] facc;
  logic [3:0]  fsum;
  logic [3:0]  fneed;
  logic [31:0] tfld;
  logic [2:0]  twt;
  logic [63:0] rem_dec;
  logic        wt_ok;

  assign vacc    = acc_r | ({57'd0, s_word.data[6:0]} << varint_shift(vcnt_r));
  assign facc    = acc_r | ({56'd0, s_word.data} << {fcnt_r, 3'b000});
  assign fsum    = {1'b0, fcnt_r} + 4'd1;
  assign fneed   = (wire_r == WT_FIX64) ? 4'd8 : 4'd4;
  assign tfld    = vacc[34:3];
  assign twt     = vacc[2:0];
  assign rem_dec = rem_r - 64'd1;
  assign wt_ok   = (twt == WT_VARINT) || (twt == WT_FIX64) || (twt == WT_LEN) ||
                   (twt == WT_FIX32);

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    vcnt_nxt    = vcnt_r;
    fcnt_nxt    = fcnt_r;
    rem_nxt     = rem_r;
    field_nxt   = field_r;
    wire_nxt    = wire_r;
    err_lat_nxt = err_lat_r;
    have        = 1'b0;
    kind        = KIND_VARINT;
    val         = 64'd0;
    err         = ERR_NONE;
    efld        = 32'd0;
    ewt         = 3'd0;
    restart     = 1'b0;
    emit        = 1'b0;
    res         = '0;

    if (err_lat_r) begin
      restart = s_word.eom;
    end else begin
      unique case (phase_r)
        PH_FIXED: begin
          if (fsum >= fneed) begin
            have      = 1'b1;
            kind      = (wire_r == WT_FIX64) ? KIND_FIX64 : KIND_FIX32;
            val       = facc;
            acc_nxt   = 64'd0;
            fcnt_nxt  = 3'd0;
            phase_nxt = PH_TAG;
          end else begin
            acc_nxt  = facc;
            fcnt_nxt = fsum[2:0];
          end
        end
        PH_PAYLOAD: begin
          have    = 1'b1;
          kind    = KIND_PAYLOAD;
          val     = {56'd0, s_word.data};
          rem_nxt = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_nxt = PH_TAG;
          end
        end
        default: begin
          if (phase_r != PH_VARINT && phase_r != PH_LEN) begin
            phase_nxt = PH_TAG;
          end
          if (s_word.data[7] && vcnt_r >= VARINT_LAST) begin
            err = ERR_LONG;
            if (phase_r == PH_VARINT || phase_r == PH_LEN) begin
              efld = field_r;
              ewt  = wire_r;
            end
          end else if (s_word.data[7]) begin
            acc_nxt  = vacc;
            vcnt_nxt = vcnt_r + 4'd1;
          end else begin
            vcnt_nxt = 4'd0;
            acc_nxt  = 64'd0;
            if (phase_r == PH_VARINT) begin
              have      = 1'b1;
              kind      = KIND_VARINT;
              val       = vacc;
              phase_nxt = PH_TAG;
            end else if (phase_r == PH_LEN) begin
              have = 1'b1;
              kind = KIND_LENHDR;
              val  = vacc;
              if (vacc == 64'd0) begin
                phase_nxt = PH_TAG;
              end else begin
                rem_nxt   = vacc;
                phase_nxt = PH_PAYLOAD;
              end
            end else if (tfld == 32'd0) begin
              err  = ERR_ZERO;
              efld = tfld;
              ewt  = twt;
            end else if (!wt_ok) begin
              err  = ERR_WIRE;
              efld = tfld;
              ewt  = twt;
            end else begin
              field_nxt = tfld;
              wire_nxt  = twt;
              fcnt_nxt  = 3'd0;
              if (twt == WT_VARINT) begin
                phase_nxt = PH_VARINT;
              end else if (twt == WT_LEN) begin
                phase_nxt = PH_LEN;
              end else begin
                phase_nxt = PH_FIXED;
              end
            end
          end
        end
      endcase

      priority if (err != ERR_NONE) begin
        emit = 1'b1;
        res  = '{KIND_ERROR, efld, ewt, 64'd0, err, 1'b1};
        if (s_word.eom) begin
          restart = 1'b1;
        end else begin
          err_lat_nxt = 1'b1;
        end
      end else if (s_word.eom && !(phase_nxt == PH_TAG && vcnt_nxt == 4'd0)) begin
        emit    = 1'b1;
        restart = 1'b1;
        if (phase_nxt == PH_TAG) begin
          res = '{KIND_ERROR, 32'd0, 3'd0, 64'd0, ERR_TRUNC, 1'b1};
        end else begin
          res = '{KIND_ERROR, field_nxt, wire_nxt, 64'd0, ERR_TRUNC, 1'b1};
        end
      end else if (have) begin
        emit    = 1'b1;
        restart = s_word.eom;
        res     = '{kind, field_r, wire_r, val, ERR_NONE, s_word.eom};
      end else begin
        restart = s_word.eom;
      end
    end
  end

  assign consume   = s_valid && (!emit || out_free);
  assign res_valid = consume && emit;

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && restart)) begin
      phase_r   <= PH_TAG;
      acc_r     <= 64'd0;
      vcnt_r    <= 4'd0;
      fcnt_r    <= 3'd0;
      rem_r     <= 64'd0;
      field_r   <= 32'd0;
      wire_r    <= 3'd0;
      err_lat_r <= 1'b0;
    end else if (consume) begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      vcnt_r    <= vcnt_nxt;
      fcnt_r    <= fcnt_nxt;
      rem_r     <= rem_nxt;
      field_r   <= field_nxt;
      wire_r    <= wire_nxt;
      err_lat_r <= err_lat_nxt;
    end
  end

  `PWT_ASSERT(a_payload_left, clk, rst_n, (phase_r == PH_PAYLOAD) |-> (rem_r != 64'd0), "payload phase with nothing left")
  `PWT_ASSERT(a_vcnt_range, clk, rst_n, vcnt_r <= VARINT_LAST, "varint byte count past ten")
  `PWT_NEVER(a_latched_silent, clk, rst_n, err_lat_r && res_valid, "result while error is latched")
  `PWT_ASSERT(a_eom_clears, clk, rst_n, (consume && s_word.eom) |=> (phase_r == PH_TAG && vcnt_r == 4'd0 && !err_lat_r), "state not cleared at end of message")
  `PWT_ASSERT(a_no_overrun, clk, rst_n, res_valid |-> out_free, "result taken while output is full")

endmodule

@@ rtl/core/pwt_out_reg.sv @@
module pwt_out_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             res_valid,
  input  pwt_pkg::tok_t                    res,
  output logic                             out_free,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pwt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [pwt_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);
  import pwt_pkg::*;

  logic valid_r;
  logic valid_nxt;
  tok_t tok_r;

  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res_valid || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      tok_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, tok_r.error_code, tok_r.value, tok_r.wire_type,
                       tok_r.field_number};
  assign out_tuser  = tok_r.kind;
  assign out_tlast  = tok_r.message_end;

endmodule

@@ rtl/core/protobuf_wire_tokenizer_top.sv @@
// Channel | Direction | tdata                  | tuser | tlast
// in_     | slave     | in_byte                | -     | end_of_message
// out_    | master    | field_number .. code   | kind  | message_end
//
// Each word is held in the input register, and the token it yields, if any, in the result register.
// A new word is taken every cycle while the result side keeps up.
// Words that produce no token never wait on the result side.
// Reset is synchronous and active low; it clears both valid flags and the decoder state.
// A stalled result holds the one word behind it in the input register.
module protobuf_wire_tokenizer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pwt_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] in_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] field_number, [34:32] wire_type, [98:35] value, [101:99] error_code
  output logic [pwt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [pwt_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [2:0] kind
  output logic                             out_tlast
);
  import pwt_pkg::*;

  logic     s_valid;
  in_word_t s_word;
  logic     consume;
  logic     out_free;
  logic     res_valid;
  tok_t     res;

  pwt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .consume   (consume),
    .s_valid   (s_valid),
    .s_word    (s_word)
  );

  pwt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_word    (s_word),
    .out_free  (out_free),
    .consume   (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  pwt_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pwt_pkg::*;

  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] b;
    bit         eom;
    bit         typed;
    tok_t       tok;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tlast;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [OUT_TUSER_W-1:0]  out_tuser;
  logic                    out_tlast;

  protobuf_wire_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  phase_t      ph = PH_TAG;
  logic [63:0] acc = '0;
  logic [3:0]  vcnt = '0;
  logic [3:0]  fcnt = '0;
  logic [63:0] pay_left = '0;
  logic [31:0] cur_field = '0;
  logic [2:0]  cur_wire = '0;
  bit          err_lat = 1'b0;

  tok_t        tokens_due[$];
  logic [7:0]  msg[$];
  int unsigned bytes_taken = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned fail_cnt = 0;
  bit          row_typed = 1'b0;
  tok_t        row_tok = '0;

  plan_row_t directed_bytes [30] = '{
    '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 32'd0, 3'd0, 64'd0, ERR_ZERO, 1'b1}},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h96, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h0b, 1'b0, 1'b1, '{KIND_ERROR, 32'd1, 3'd3, 64'd0, ERR_WIRE, 1'b1}},
    '{8'h55, 1'b1, 1'b0, '0},
    '{8'h0d, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'hab, 1'b0, 1'b0, '0},
    '{8'hcd, 1'b0, 1'b0, '0},
    '{8'h1a, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b1, '{KIND_ERROR, 32'd1, WT_VARINT, 64'd0, ERR_LONG, 1'b1}},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h05, 1'b1, 1'b1, '{KIND_ERROR, 32'd2, WT_LEN, 64'd0, ERR_TRUNC, 1'b1}}
  };

  task automatic clear_state();
    ph = PH_TAG;
    acc = '0;
    vcnt = '0;
    fcnt = '0;
    pay_left = '0;
    cur_field = '0;
    cur_wire = '0;
    err_lat = 1'b0;
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eom, output bit got,
                               output tok_t t);
    logic [63:0] v;
    logic [63:0] val;
    logic [31:0] f;
    logic [31:0] efld;
    logic [2:0]  w;
    logic [2:0]  ewt;
    logic [2:0]  kind;
    logic [2:0]  err;
    bit          have;
    got = 1'b0;
    t = '0;
    have = 1'b0;
    kind = KIND_VARINT;
    err = ERR_NONE;
    efld = '0;
    ewt = '0;
    val = '0;
    if (err_lat) begin
      if (eom) clear_state();
      return;
    end
    case (ph)
      PH_FIXED: begin
        acc |= 64'(c) << (8 * fcnt[2:0]);
        fcnt = fcnt + 4'd1;
        if (fcnt >= ((cur_wire == WT_FIX64) ? 4'd8 : 4'd4)) begin
          have = 1'b1;
          kind = (cur_wire == WT_FIX64) ? KIND_FIX64 : KIND_FIX32;
          val = acc;
          acc = '0;
          fcnt = '0;
          ph = PH_TAG;
        end
      end
      PH_PAYLOAD: begin
        have = 1'b1;
        kind = KIND_PAYLOAD;
        val = 64'(c);
        pay_left = pay_left - 64'd1;
        if (pay_left == 0) ph = PH_TAG;
      end
      default: begin
        if (c[7] && vcnt >= VARINT_LAST) begin
          err = ERR_LONG;
          if (ph != PH_TAG) begin
            efld = cur_field;
            ewt = cur_wire;
          end
        end else begin
          acc |= 64'(c[6:0]) << (7 * (vcnt % 10));
          if (c[7]) begin
            vcnt = vcnt + 4'd1;
          end else begin
            vcnt = '0;
            v = acc;
            acc = '0;
            if (ph == PH_TAG) begin
              f = v[34:3];
              w = v[2:0];
              if (v == 0 || f == 0) begin
                err = ERR_ZERO;
                efld = f;
                ewt = w;
              end else if (!(w inside {WT_VARINT, WT_FIX64, WT_LEN, WT_FIX32})) begin
                err = ERR_WIRE;
                efld = f;
                ewt = w;
              end else begin
                cur_field = f;
                cur_wire = w;
                fcnt = '0;
                ph = (w == WT_VARINT) ? PH_VARINT : (w == WT_LEN) ? PH_LEN : PH_FIXED;
              end
            end else if (ph == PH_VARINT) begin
              have = 1'b1;
              kind = KIND_VARINT;
              val = v;
              ph = PH_TAG;
            end else begin
              have = 1'b1;
              kind = KIND_LENHDR;
              val = v;
              if (v == 0) begin
                ph = PH_TAG;
              end else begin
                pay_left = v;
                ph = PH_PAYLOAD;
              end
            end
          end
        end
      end
    endcase
    if (err != ERR_NONE) begin
      got = 1'b1;
      t.kind = KIND_ERROR;
      t.field_number = efld;
      t.wire_type = ewt;
      t.error_code = err;
      t.message_end = 1'b1;
      if (eom) clear_state();
      else err_lat = 1'b1;
      return;
    end
    if (eom && !(ph == PH_TAG && vcnt == 0)) begin
      got = 1'b1;
      t.kind = KIND_ERROR;
      t.field_number = (ph == PH_TAG) ? 32'd0 : cur_field;
      t.wire_type = (ph == PH_TAG) ? 3'd0 : cur_wire;
      t.error_code = ERR_TRUNC;
      t.message_end = 1'b1;
      clear_state();
      return;
    end
    if (have) begin
      got = 1'b1;
      t.kind = kind;
      t.field_number = cur_field;
      t.wire_type = cur_wire;
      t.value = val;
      t.error_code = ERR_NONE;
      t.message_end = eom;
    end
    if (eom) clear_state();
  endtask

  task automatic note_failure(input string what, input tok_t want, input tok_t seen);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t %s: expected kind %0d field %0d wire %0d value %h code %0d end %0b",
               $realtime, what, want.kind, want.field_number, want.wire_type, want.value,
               want.error_code, want.message_end);
    if (fail_cnt <= 10)
      $display("    got kind %0d field %0d wire %0d value %h code %0d end %0b",
               seen.kind, seen.field_number, seen.wire_type, seen.value,
               seen.error_code, seen.message_end);
  endtask

  always @(posedge clk) begin : watch_ports
    tok_t pred;
    tok_t seen;
    bit   got;
    if (rst_n === 1'b1 && in_tvalid && in_tready) begin
      tokenize_byte(in_tdata, in_tlast, got, pred);
      // A row with a typed token checks the block directly; the predictor still advances.
      if (row_typed) begin
        pred = row_tok;
        got = 1'b1;
      end
      if (got) tokens_due.insert(tokens_due.size(), pred);
      bytes_taken++;
    end
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      seen.kind = out_tuser;
      seen.field_number = out_tdata[31:0];
      seen.wire_type = out_tdata[34:32];
      seen.value = out_tdata[98:35];
      seen.error_code = out_tdata[101:99];
      seen.message_end = out_tlast;
      if (tokens_due.size() == 0) begin
        note_failure("unexpected word", '0, seen);
      end else begin
        pred = tokens_due.pop_front();
        if (seen !== pred) note_failure("mismatch", pred, seen);
      end
    end
  end

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return '1;
    return v >> $urandom_range(0, 63);
  endfunction

  task automatic add_msg_byte(input logic [7:0] b);
    msg.insert(msg.size(), b);
  endtask

  task automatic put_varint(input logic [63:0] v, input int len_min);
    logic [63:0] r;
    logic [7:0]  b;
    int          i;
    r = v;
    i = 0;
    do begin
      b = {1'b0, r[6:0]};
      r = r >> 7;
      i++;
      if ((r != 0 || i < len_min) && i < 10) b[7] = 1'b1;
      if (i == 10) b[6:1] = 6'($urandom);
      add_msg_byte(b);
    end while (b[7]);
  endtask

  task automatic put_field();
    logic [31:0] fld;
    logic [2:0]  wt;
    logic [63:0] tag;
    int          pad;
    int          n;
    case ($urandom_range(0, 3))
      0, 1: fld = $urandom_range(1, 20);
      2: fld = $urandom_range(1, 32'h1fff_ffff);
      default: fld = $urandom;
    endcase
    if (fld == 0) fld = 32'd1;
    case ($urandom_range(0, 3))
      0: wt = WT_VARINT;
      1: wt = WT_FIX64;
      2: wt = WT_LEN;
      default: wt = WT_FIX32;
    endcase
    tag = {29'd0, fld, wt};
    if ($urandom_range(0, 15) == 0) tag[63:35] = 29'($urandom);
    pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
    put_varint(tag, pad);
    pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
    case (wt)
      WT_VARINT: put_varint(rand_value(), pad);
      WT_FIX64: repeat (8) add_msg_byte(8'($urandom));
      WT_FIX32: repeat (4) add_msg_byte(8'($urandom));
      default: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        put_varint(64'(n), pad);
        repeat (n) add_msg_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic build_message();
    logic [2:0] bad_wt [4];
    bad_wt = '{3'd3, 3'd4, 3'd6, 3'd7};
    msg.delete();
    repeat ($urandom_range(1, 5)) put_field();
    case ($urandom_range(0, 15))
      0: repeat ($urandom_range(1, 4)) if (msg.size() > 1) void'(msg.pop_back());
      1: begin
        msg.delete();
        repeat ($urandom_range(1, 12)) add_msg_byte(8'($urandom));
      end
      2: begin
        put_varint({29'd0, 32'($urandom_range(1, 40)), bad_wt[$urandom_range(0, 3)]}, 0);
        repeat ($urandom_range(0, 3)) add_msg_byte(8'($urandom));
      end
      3: begin
        put_varint({29'd0, 32'd0, 3'($urandom)}, 0);
        repeat ($urandom_range(0, 3)) add_msg_byte(8'($urandom));
      end
      4: begin
        if ($urandom_range(0, 1) == 1) put_varint({29'd0, 32'd5, WT_VARINT}, 0);
        repeat ($urandom_range(10, 12)) add_msg_byte(8'h80 | 8'($urandom));
      end
      5: begin
        put_varint({29'd0, 32'd9, WT_LEN}, 0);
        put_varint(rand_value() | 64'd100, 0);
        repeat ($urandom_range(0, 5)) add_msg_byte(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic offer(input logic [7:0] b, input bit eom, input bit typed, input tok_t tok);
    int unsigned taken0;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    taken0 = bytes_taken;
    row_typed = typed;
    row_tok = tok;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eom;
    do @(negedge clk); while (bytes_taken == taken0);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tokens_due.size() != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_bytes[i])
      offer(directed_bytes[i].b, directed_bytes[i].eom, directed_bytes[i].typed,
            directed_bytes[i].tok);
    wait_drained();
    while (bytes_sent < ITEM_TARGET) begin
      build_message();
      foreach (msg[i]) offer(msg[i], i == msg.size() - 1, 1'b0, '0);
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && tokens_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned seg_left;
    int unsigned seg_mode;
    bit          held;
    out_tready = 1'b0;
    seg_left = 0;
    seg_mode = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && bytes_taken >= 150) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 60);
          seg_mode = $urandom_range(0, 3);
        end
        seg_left--;
        out_tready <= (seg_mode == 0) || ($urandom_range(1, 4) <= 4 - seg_mode);
      end
    end
  end

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pwt_pkg.sv
rtl/core/pwt_in_stage.sv
rtl/core/pwt_core.sv
rtl/core/pwt_out_reg.sv
rtl/core/protobuf_wire_tokenizer_top.sv
test/tb_top.sv
